// ===== src/position_settle_detector_defines.svh =====
// assertion helpers for the position settle detector
`ifndef POSITION_SETTLE_DETECTOR_DEFINES_SVH
`define POSITION_SETTLE_DETECTOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define PSD_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/psd_pkg.sv =====
`default_nettype none

package psd_pkg;

  localparam int unsigned MAX_ENTRIES = 512;
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_POLLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINGER_POLLS = 2'd2;

  localparam logic [7:0] MOVE_THRESHOLD_RST = 8'd4;
  localparam logic [3:0] STABLE_POLLS_RST = 4'd2;
  localparam logic [7:0] LINGER_POLLS_RST = 8'd20;

  localparam int unsigned IN_DATA_W = 64;
  localparam int unsigned OUT_DATA_W = 8;

  // bit positions of the result fields in the output tdata
  localparam int unsigned OUT_CHANGED_BIT = 0;
  localparam int unsigned OUT_TRIGGER_BIT = 1;
  localparam int unsigned OUT_FAST_BIT = 2;

  typedef struct packed {
    logic fast_poll;
    logic settle_trigger;
    logic snapshot_changed;
  } result_t;

endpackage

`default_nettype wire

// ===== src/position_settle_detector.sv =====
// position_settle_detector
//
// input stream: one transaction per snapshot entry. tuser = entry_present,
// tdata = {pos_y, pos_x, window_id}, tlast marks the final transaction of a
// poll. an empty poll is a single transaction with tuser low and tlast high.
// output stream: one transaction per poll, sent after its tlast transaction.
// configuration: cfg_we writes cfg_data into register cfg_index at the
// clock edge; write only while no poll is in flight.
// throughput: one input transaction per cycle while s_tready is high, through
// the one compare stage that follows the snapshot memory read; a result
// passes the compare stage and the output queue before it leaves the block.
// snapshots live in two banks of MAX_ENTRIES entries, one read and one
// written per poll; entries beyond MAX_ENTRIES in one poll are dropped.
// reset clears all control state; the banks need no clearing because only
// entries written by the poll that set the baseline are ever compared.
// a two-entry output queue absorbs receiver stalls; s_tready drops only when
// results already queued or in flight would overfill it.

`default_nettype none

module position_settle_detector (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [psd_pkg::IN_DATA_W-1:0]       s_tdata,   // window_id, pos_x, pos_y
  input  wire logic                                s_tuser,   // entry_present
  input  wire logic                                s_tlast,   // last_of_poll
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [psd_pkg::OUT_DATA_W-1:0]           m_tdata,   // snapshot_changed, settle_trigger, fast_poll, zero pad
  input  wire logic                                cfg_we,
  input  wire logic [psd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [psd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned IDX_W = psd_pkg::IDX_W;
  localparam int unsigned CNT_W = psd_pkg::CNT_W;

  // configuration registers
  logic [7:0] move_threshold;
  logic [3:0] stable_polls_needed;
  logic [7:0] linger_polls;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_threshold      <= psd_pkg::MOVE_THRESHOLD_RST;
      stable_polls_needed <= psd_pkg::STABLE_POLLS_RST;
      linger_polls        <= psd_pkg::LINGER_POLLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psd_pkg::REG_MOVE_THRESHOLD: move_threshold <= cfg_data;
        psd_pkg::REG_STABLE_POLLS:   stable_polls_needed <= cfg_data[3:0];
        psd_pkg::REG_LINGER_POLLS:   linger_polls <= cfg_data;
        default: ;
      endcase
    end
  end

  // input fields
  logic        in_fire;
  logic [31:0] in_id;
  logic [15:0] in_x;
  logic [15:0] in_y;
  logic        in_store;

  assign in_fire = s_tvalid && s_tready;
  assign in_id   = s_tdata[31:0];
  assign in_x    = s_tdata[47:32];
  assign in_y    = s_tdata[63:48];

  // entry counter of the poll being received
  logic [CNT_W-1:0] entry_index;

  assign in_store = s_tuser && (entry_index < CNT_W'(psd_pkg::MAX_ENTRIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_index <= '0;
    end else if (in_fire) begin
      if (s_tlast) begin
        entry_index <= '0;
      end else if (in_store) begin
        entry_index <= entry_index + CNT_W'(1);
      end
    end
  end

  // compare stage
  logic             s1_valid;
  logic             s1_store;
  logic             s1_last;
  logic [IDX_W-1:0] s1_idx;
  logic [CNT_W-1:0] s1_count;
  logic [31:0]      s1_id;
  logic [15:0]      s1_x;
  logic [15:0]      s1_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_store <= in_store;
      s1_last  <= s_tlast;
      s1_idx   <= entry_index[IDX_W-1:0];
      s1_count <= in_store ? entry_index + CNT_W'(1) : entry_index;
      s1_id    <= in_id;
      s1_x     <= in_x;
      s1_y     <= in_y;
    end
  end

  // poll state
  logic             baseline_bank;
  logic [CNT_W-1:0] baseline_count;
  logic             mismatch_seen;
  logic             baseline_loaded;
  logic             armed;
  logic [3:0]       quiet_count;
  logic [7:0]       linger_count;
  logic             fast_mode;

  // snapshot banks
  logic [63:0] bank0_mem [psd_pkg::MAX_ENTRIES];
  logic [63:0] bank1_mem [psd_pkg::MAX_ENTRIES];
  logic [63:0] bank0_rd;
  logic [63:0] bank1_rd;
  logic        wr_en;
  logic        wr_bank;
  logic [63:0] wr_word;

  assign wr_en   = s1_valid && s1_store;
  assign wr_bank = ~baseline_bank;
  assign wr_word = {s1_id, s1_x, s1_y};

  always_ff @(posedge clk) begin
    if (wr_en && !wr_bank) begin
      bank0_mem[s1_idx] <= wr_word;
    end
    if (wr_en && wr_bank) begin
      bank1_mem[s1_idx] <= wr_word;
    end
    if (in_fire) begin
      bank0_rd <= bank0_mem[entry_index[IDX_W-1:0]];
      bank1_rd <= bank1_mem[entry_index[IDX_W-1:0]];
    end
  end

  // forwarding of the write that landed at the same edge as the read
  logic             fwd_valid;
  logic             fwd_bank;
  logic [IDX_W-1:0] fwd_idx;
  logic [63:0]      fwd_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_bank <= wr_bank;
      fwd_idx  <= s1_idx;
      fwd_word <= wr_word;
    end
  end

  logic [63:0] old_word;
  logic [16:0] dx;
  logic [16:0] dy;
  logic [16:0] adx;
  logic [16:0] ady;
  logic        cmp_en;
  logic        entry_miss;
  logic        mis_now;

  always_comb begin
    if (fwd_valid && (fwd_bank == baseline_bank) && (fwd_idx == s1_idx)) begin
      old_word = fwd_word;
    end else begin
      old_word = baseline_bank ? bank1_rd : bank0_rd;
    end
  end

  assign dx  = {s1_x[15], s1_x} - {old_word[31], old_word[31:16]};
  assign dy  = {s1_y[15], s1_y} - {old_word[15], old_word[15:0]};
  assign adx = dx[16] ? (17'd0 - dx) : dx;
  assign ady = dy[16] ? (17'd0 - dy) : dy;

  assign cmp_en     = s1_store && (CNT_W'(s1_idx) < baseline_count);
  assign entry_miss = (old_word[63:32] != s1_id) ||
                      (adx > {9'd0, move_threshold}) ||
                      (ady > {9'd0, move_threshold});
  assign mis_now    = mismatch_seen || (cmp_en && entry_miss);

  // end-of-poll decision
  logic             baseline_bank_next;
  logic [CNT_W-1:0] baseline_count_next;
  logic             mismatch_seen_next;
  logic             baseline_loaded_next;
  logic             armed_next;
  logic [3:0]       quiet_count_next;
  logic [7:0]       linger_count_next;
  logic             fast_mode_next;
  logic [3:0]       quiet_inc;
  logic             res_push;
  psd_pkg::result_t res;

  assign quiet_inc = (quiet_count != 4'hF) ? quiet_count + 4'd1 : quiet_count;
  assign res_push  = s1_valid && s1_last;

  always_comb begin
    baseline_bank_next   = baseline_bank;
    baseline_count_next  = baseline_count;
    mismatch_seen_next   = mismatch_seen;
    baseline_loaded_next = baseline_loaded;
    armed_next           = armed;
    quiet_count_next     = quiet_count;
    linger_count_next    = linger_count;
    fast_mode_next       = fast_mode;
    res.snapshot_changed = 1'b0;
    res.settle_trigger   = 1'b0;
    if (s1_valid) begin
      mismatch_seen_next = mis_now;
      if (s1_last) begin
        mismatch_seen_next = 1'b0;
        if (!baseline_loaded) begin
          baseline_bank_next   = ~baseline_bank;
          baseline_count_next  = s1_count;
          baseline_loaded_next = 1'b1;
        end else if (mis_now || (s1_count != baseline_count)) begin
          res.snapshot_changed = 1'b1;
          baseline_bank_next   = ~baseline_bank;
          baseline_count_next  = s1_count;
          armed_next           = 1'b1;
          quiet_count_next     = 4'd0;
          fast_mode_next       = 1'b1;
          linger_count_next    = linger_polls;
        end else if (armed) begin
          if (quiet_inc >= stable_polls_needed) begin
            res.settle_trigger = 1'b1;
            armed_next         = 1'b0;
            quiet_count_next   = 4'd0;
          end else begin
            quiet_count_next = quiet_inc;
          end
        end else if (linger_count != 8'd0) begin
          linger_count_next = linger_count - 8'd1;
          if (linger_count == 8'd1) begin
            fast_mode_next = 1'b0;
          end
        end else begin
          fast_mode_next = 1'b0;
        end
      end
    end
    res.fast_poll = fast_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_bank   <= 1'b0;
      baseline_count  <= '0;
      mismatch_seen   <= 1'b0;
      baseline_loaded <= 1'b0;
      armed           <= 1'b0;
      quiet_count     <= 4'd0;
      linger_count    <= 8'd0;
      fast_mode       <= 1'b0;
    end else begin
      baseline_bank   <= baseline_bank_next;
      baseline_count  <= baseline_count_next;
      mismatch_seen   <= mismatch_seen_next;
      baseline_loaded <= baseline_loaded_next;
      armed           <= armed_next;
      quiet_count     <= quiet_count_next;
      linger_count    <= linger_count_next;
      fast_mode       <= fast_mode_next;
    end
  end

  // two-entry output queue
  psd_pkg::result_t out_q [2];
  logic             out_wr_ptr;
  logic             out_rd_ptr;
  logic [1:0]       out_count;
  logic             out_pop;
  logic [2:0]       out_room_need;

  assign out_pop       = m_tvalid && m_tready;
  assign out_room_need = {1'b0, out_count} + {2'd0, res_push} - {2'd0, out_pop};
  assign s_tready      = (out_room_need <= 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= 1'b0;
      out_rd_ptr <= 1'b0;
      out_count  <= 2'd0;
    end else begin
      if (res_push) begin
        out_wr_ptr <= ~out_wr_ptr;
      end
      if (out_pop) begin
        out_rd_ptr <= ~out_rd_ptr;
      end
      out_count <= out_count + {1'b0, res_push} - {1'b0, out_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_q[out_wr_ptr] <= res;
    end
  end

  psd_pkg::result_t out_head;

  assign out_head = out_q[out_rd_ptr];
  assign m_tvalid = (out_count != 2'd0);

  always_comb begin
    m_tdata = '0;
    m_tdata[psd_pkg::OUT_CHANGED_BIT] = out_head.snapshot_changed;
    m_tdata[psd_pkg::OUT_TRIGGER_BIT] = out_head.settle_trigger;
    m_tdata[psd_pkg::OUT_FAST_BIT]    = out_head.fast_poll;
  end

endmodule

`default_nettype wire

// ===== src/psd_checker.sv =====
`default_nettype none

`include "position_settle_detector_defines.svh"

module psd_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [psd_pkg::OUT_DATA_W-1:0]  m_tdata
);

  // stalled result holds
  `PSD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

  // nothing leaves right after reset
  `PSD_ASSERT_NEXT_RST(a_reset_idle, rst, !m_tvalid, "result shown right after reset")

  // a change and a trigger never share a poll
  `PSD_ASSERT_NOW(a_change_xor_trigger, m_tvalid, !(m_tdata[psd_pkg::OUT_CHANGED_BIT] && m_tdata[psd_pkg::OUT_TRIGGER_BIT]), "change and trigger in one poll")

  // a change always selects fast polling
  `PSD_ASSERT_NOW(a_change_fast, m_tvalid && m_tdata[psd_pkg::OUT_CHANGED_BIT], m_tdata[psd_pkg::OUT_FAST_BIT], "change without fast polling")

endmodule

bind position_settle_detector psd_checker u_psd_checker (.*);

`default_nettype wire

// ===== tb/tb_position_settle_detector.sv =====
`default_nettype none

module tb_position_settle_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import psd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 100;
  localparam int NUM_PHASES = 7;

  class poll_scoreboard;
    bit [63:0]   snap_mem [2][MAX_ENTRIES];
    bit          base_bank;
    int unsigned base_cnt;
    int unsigned entry_idx;
    bit          differs;
    bit          loaded;
    bit          armed;
    bit [3:0]    quiet_polls;
    bit [7:0]    linger_left;
    bit          fast;
    bit [7:0]    jitter_max;
    bit [3:0]    quiet_needed;
    bit [7:0]    linger_reload;
    result_t     expected_status[$];
    int          errors;

    function new();
      jitter_max = MOVE_THRESHOLD_RST;
      quiet_needed = STABLE_POLLS_RST;
      linger_reload = LINGER_POLLS_RST;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MOVE_THRESHOLD: jitter_max = val;
        REG_STABLE_POLLS: quiet_needed = val[3:0];
        REG_LINGER_POLLS: linger_reload = val;
        default: ;
      endcase
    endfunction

    function int unsigned pixel_step(logic [15:0] a, logic [15:0] b);
      int d;
      d = int'($signed(a)) - int'($signed(b));
      return (d < 0) ? -d : d;
    endfunction

    // one accepted transaction; a poll end queues the expected status
    function void note_entry(bit present, bit [31:0] id, bit [15:0] x, bit [15:0] y,
                             bit last);
      bit [63:0] old;
      result_t res;
      if (present && entry_idx < MAX_ENTRIES) begin
        if (entry_idx < base_cnt) begin
          old = snap_mem[base_bank][entry_idx];
          if (old[63:32] != id || pixel_step(x, old[31:16]) > jitter_max ||
              pixel_step(y, old[15:0]) > jitter_max)
            differs = 1'b1;
        end
        snap_mem[!base_bank][entry_idx] = {id, x, y};
        entry_idx++;
      end
      if (!last) return;
      res = '0;
      if (!loaded) begin
        base_bank = !base_bank;
        base_cnt = entry_idx;
        loaded = 1'b1;
      end else if (differs || entry_idx != base_cnt) begin
        res.snapshot_changed = 1'b1;
        base_bank = !base_bank;
        base_cnt = entry_idx;
        armed = 1'b1;
        quiet_polls = '0;
        fast = 1'b1;
        linger_left = linger_reload;
      end else if (armed) begin
        if (quiet_polls < 4'd15) quiet_polls++;
        if (quiet_polls >= quiet_needed) begin
          res.settle_trigger = 1'b1;
          armed = 1'b0;
          quiet_polls = '0;
        end
      end else if (linger_left > 0) begin
        linger_left--;
        if (linger_left == 0) fast = 1'b0;
      end else begin
        fast = 1'b0;
      end
      entry_idx = 0;
      differs = 1'b0;
      res.fast_poll = fast;
      expected_status.push_back(res);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] tdata);
      result_t got, want;
      got.snapshot_changed = tdata[OUT_CHANGED_BIT];
      got.settle_trigger = tdata[OUT_TRIGGER_BIT];
      got.fast_poll = tdata[OUT_FAST_BIT];
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %b", $time, got);
        errors++;
        return;
      end
      want = expected_status.pop_front();
      if (got.snapshot_changed !== want.snapshot_changed) begin
        $display("%0t: snapshot_changed expected %b actual %b", $time,
                 want.snapshot_changed, got.snapshot_changed);
        errors++;
      end
      if (got.settle_trigger !== want.settle_trigger) begin
        $display("%0t: settle_trigger expected %b actual %b", $time,
                 want.settle_trigger, got.settle_trigger);
        errors++;
      end
      if (got.fast_poll !== want.fast_poll) begin
        $display("%0t: fast_poll expected %b actual %b", $time,
                 want.fast_poll, got.fast_poll);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;   // window_id, pos_x, pos_y
  logic                   s_tuser;   // entry_present
  logic                   s_tlast;   // last_of_poll
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;   // snapshot_changed, settle_trigger, fast_poll, zero pad
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  poll_scoreboard sb;
  int             cycle_cnt;
  int             items_sent;
  int             tx_idle_pct;
  int             rx_stall_pct;
  bit             no_idle;
  bit [31:0]      lay_id[$];
  bit [15:0]      lay_x[$];
  bit [15:0]      lay_y[$];

  position_settle_detector uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // receiver stalls in bursts
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(0, 99) < rx_stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push_item(bit present, bit [31:0] id, bit [15:0] x, bit [15:0] y,
                           bit last);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {y, x, id};
    s_tuser <= present;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_entry(present, id, x, y, last);
    if (present || last) items_sent++;
  endtask

  task automatic pause_stream();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_status.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic program_regs(bit [7:0] thr, bit [3:0] need, bit [7:0] linger);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_MOVE_THRESHOLD;
    cfg_data <= thr;
    sb.set_reg(REG_MOVE_THRESHOLD, thr);
    @(negedge clk);
    cfg_index <= REG_STABLE_POLLS;
    cfg_data <= 8'(need);
    sb.set_reg(REG_STABLE_POLLS, 8'(need));
    @(negedge clk);
    cfg_index <= REG_LINGER_POLLS;
    cfg_data <= linger;
    sb.set_reg(REG_LINGER_POLLS, linger);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic build_layout(int n);
    lay_id.delete();
    lay_x.delete();
    lay_y.delete();
    repeat (n) lay_id.push_back($urandom);
    lay_id.sort();
    repeat (n) begin
      lay_x.push_back(16'($urandom));
      lay_y.push_back(16'($urandom));
    end
  endtask

  // one poll of the current layout, each coordinate moved by up to +-jit
  task automatic send_layout(int jit);
    int  n;
    bit  tail_empty;
    bit [15:0] x, y;
    n = lay_id.size();
    tail_empty = (n == 0) || ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        push_item(1'b0, $urandom, 16'($urandom), 16'($urandom), 1'b0);
      x = lay_x[i] + 16'(int'($urandom_range(0, 2 * jit)) - jit);
      y = lay_y[i] + 16'(int'($urandom_range(0, 2 * jit)) - jit);
      push_item(1'b1, lay_id[i], x, y, !tail_empty && i == n - 1);
    end
    if (tail_empty) push_item(1'b0, $urandom, 16'($urandom), 16'($urandom), 1'b1);
  endtask

  task automatic random_poll(int chg_pct);
    int k;
    if ($urandom_range(0, 99) < chg_pct || lay_id.size() == 0) begin
      k = (lay_id.size() == 0) ? 0 : $urandom_range(0, lay_id.size() - 1);
      case ($urandom_range(0, 2))
        0: build_layout($urandom_range(0, 8));
        1: if (lay_id.size() != 0) begin
          if ($urandom_range(0, 1)) lay_x[k] += 16'(sb.jitter_max + 1 + $urandom_range(0, 40));
          else lay_y[k] -= 16'(sb.jitter_max + 1 + $urandom_range(0, 40));
        end else begin
          build_layout($urandom_range(1, 8));
        end
        default: if (lay_id.size() != 0) lay_id[k] += 32'd1;
        else build_layout($urandom_range(1, 8));
      endcase
      send_layout(0);
    end else begin
      send_layout(sb.jitter_max);
    end
  endtask

  initial begin
    int chg_pct;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MOVE_THRESHOLD;
    cfg_data = '0;
    no_idle = 1'b0;
    tx_idle_pct = 10;
    rx_stall_pct = 10;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first poll only loads the baseline
    push_item(1'b1, 32'h0, -16'sd32768, 16'sd32767, 1'b0);
    push_item(1'b1, 32'hFFFF_FFFF, 16'sd32767, -16'sd32768, 1'b1);
    // jitter right at the threshold is quiet
    push_item(1'b1, 32'h0, -16'sd32764, 16'sd32763, 1'b0);
    push_item(1'b1, 32'hFFFF_FFFF, 16'sd32763, -16'sd32764, 1'b1);
    // one pixel over the threshold, then quiet polls up to the trigger
    repeat (3) begin
      push_item(1'b1, 32'h0, -16'sd32763, 16'sd32767, 1'b0);
      push_item(1'b1, 32'hFFFF_FFFF, 16'sd32767, -16'sd32768, 1'b1);
    end
    // empty polls
    push_item(1'b0, $urandom, 16'($urandom), 16'($urandom), 1'b1);
    push_item(1'b0, $urandom, 16'($urandom), 16'($urandom), 1'b1);
    // empty transaction inside a poll, poll closed by an empty transaction
    push_item(1'b0, $urandom, 16'($urandom), 16'($urandom), 1'b0);
    push_item(1'b1, 32'd5, 16'd0, 16'd0, 1'b0);
    push_item(1'b0, $urandom, 16'($urandom), 16'($urandom), 1'b1);
    // id change at the same count
    push_item(1'b1, 32'd6, 16'd0, 16'd0, 1'b1);
    pause_stream();

    // zero threshold, zero stable count, zero linger
    program_regs(8'd0, 4'd0, 8'd0);
    push_item(1'b1, 32'd6, 16'sd32767, -16'sd1, 1'b1);
    push_item(1'b1, 32'd6, -16'sd32768, -16'sd1, 1'b1);
    push_item(1'b1, 32'd6, -16'sd32768, -16'sd1, 1'b1);
    push_item(1'b1, 32'd6, -16'sd32768, -16'sd1, 1'b1);
    push_item(1'b1, 32'd6, -16'sd32767, -16'sd1, 1'b1);
    pause_stream();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          program_regs(8'd0, 4'd1, 8'd0);
          chg_pct = 20;
        end
        1: begin
          program_regs(8'd255, 4'd15, 8'd255);
          chg_pct = 3;
        end
        2: begin
          program_regs(8'($urandom), 4'd0, 8'($urandom_range(0, 5)));
          chg_pct = 15;
        end
        default: begin
          program_regs(8'($urandom), 4'($urandom_range(1, 15)), 8'($urandom_range(0, 30)));
          chg_pct = $urandom_range(3, 30);
        end
      endcase
      no_idle = (p == NUM_PHASES - 1);
      tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
      rx_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);

      if (p == 3) begin
        // over capacity: entries past the store size are dropped
        build_layout(MAX_ENTRIES + $urandom_range(0, 6));
        send_layout(0);
        for (int i = MAX_ENTRIES; i < lay_id.size(); i++) begin
          lay_id[i] = $urandom;
          lay_x[i] = 16'($urandom);
        end
        send_layout(sb.jitter_max);
      end

      build_layout($urandom_range(1, 6));
      begin
        int target;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target) random_poll(chg_pct);
      end
      pause_stream();
    end

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/psd_pkg.sv
src/position_settle_detector.sv
src/psd_checker.sv
tb/tb_position_settle_detector.sv
